[rtl/core/vpa_pkg.sv]
`default_nettype none
package vpa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_WORST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_FIRST = 2'd2,
    FIT_SPARE = 2'd3
  } fit_t;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_SPLIT      = 1'b1;
  localparam logic FUNC_ALLOC     = 1'b0;
  localparam logic FUNC_RELEASE   = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] request_size;
    logic [15:0] block_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] granted_address;
    logic [15:0] granted_length;
    logic [15:0] granted_id;
  } out_word_t;

  // One table entry; addresses and lengths carry five bits of headroom over the 16-bit request fields.
  typedef struct packed {
    logic        valid;
    logic        used;
    logic [20:0] start;
    logic [20:0] length;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE,
    S_WRITE,
    S_DONE
  } state_t;

  // Controller commands to the cells for one rotation step.
  typedef struct packed {
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/vpa_cell.sv]
`default_nettype none
module vpa_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             init_valid,
  input  vpa_pkg::entry_t       init_entry,
  input  vpa_pkg::cell_ctl_t    ctl,
  input  wire logic             load,
  input  vpa_pkg::entry_t       load_entry,
  input  vpa_pkg::entry_t       prev_entry,
  output vpa_pkg::entry_t       entry
);
  import vpa_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  entry_t entry_init;

  always_comb begin
    entry_init       = init_entry;
    entry_init.valid = init_valid;
  end

  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = load_entry;
    end else if (ctl.shift) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= entry_init;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

[rtl/core/variable_partition_allocator.sv]
// Variable partition allocator.
// A request word is taken on in_word when start is high and busy is low.
// func 0 allocates request_size bytes from a free partition picked by the
// fit policy; func 1 releases the partition holding block_id and merges it
// with free neighbours. Exactly one result word follows each request, shown
// on out_word for one cycle with out_valid high; the receiver cannot stall.
// The table is a ring of TABLE_ENTRIES cells that rotates one place per
// cycle, while a request is searched or merged, past a single examine point
// at cell 0. Each request takes one full rotation to search, then a decide
// step and a write-back step; a successful release adds a second rotation to
// find free neighbours. The result word is shown before busy falls, and the
// next request is taken only after that result word, so requests never
// overlap in the cell ring.
// Configuration writes on cfg_valid/cfg_ready are taken at any time; they
// are meant to happen only while busy is low.
// After reset the table holds one free partition covering the memory,
// fit policy is first fit and the split threshold is 16.
`default_nettype none
module variable_partition_allocator #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MEMORY_BYTES  = 32768,
  parameter int BASE_ADDRESS  = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  vpa_pkg::in_word_t   in_word,
  output logic                out_valid,
  output vpa_pkg::out_word_t  out_word,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [0:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import vpa_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [1:0]  fit_r;
  logic [15:0] thr_r;
  state_t      state_r, state_nxt;
  in_word_t    req_r;
  logic [CW-1:0] cnt_r;
  logic [15:0] last_id_r;
  out_word_t   out_r;
  logic        out_v_r;

  // Scan results, positions counted in rotation steps from the start.
  logic          pick_ok_r, slot_ok_r, rel_ok_r;
  logic [IW-1:0] pick_pos_r, slot_pos_r;
  entry_t        pick_e_r;
  entry_t        k_e_r;
  logic          above_ok_r, below_ok_r;
  entry_t        below_e_r;
  logic [IW-1:0] above_pos_r, below_pos_r;
  logic [IW-1:0] k_pos_r;
  entry_t        new_k_r, new_slot_r;
  logic          do_split_r;

  entry_t cells [TABLE_ENTRIES];
  logic   load [TABLE_ENTRIES];
  entry_t load_e [TABLE_ENTRIES];
  cell_ctl_t ctl;
  entry_t init_e;
  entry_t head;
  logic [IW-1:0] pos;

  assign pos  = cnt_r[IW-1:0];
  assign head = cells[0];

  always_comb begin
    init_e        = '0;
    init_e.start  = 21'(BASE_ADDRESS);
    init_e.length = 21'(MEMORY_BYTES);
    init_e.tag    = 16'd1;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      vpa_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_valid(g == 0),
        .init_entry(g == 0 ? init_e : entry_t'('0)),
        .ctl       (ctl),
        .load      (load[g]),
        .load_entry(load_e[g]),
        .prev_entry(cells[(g + 1) % TABLE_ENTRIES]),
        .entry     (cells[g])
      );
    end
  endgenerate

  // Better-than test for the allocation search.
  logic fits, better;
  always_comb begin
    fits = head.valid && !head.used && (head.length > {5'd0, req_r.request_size});
    case (fit_r)
      FIT_WORST: better = head.length > pick_e_r.length ||
                          (head.length == pick_e_r.length && head.start < pick_e_r.start);
      FIT_BEST:  better = head.length < pick_e_r.length ||
                          (head.length == pick_e_r.length && head.start < pick_e_r.start);
      default:   better = head.start < pick_e_r.start;
    endcase
  end

  logic last_step;
  assign last_step = (cnt_r == CW'(TABLE_ENTRIES - 1));

  // Outcome of a request, taken into registers in the decide cycle.
  logic [20:0] rem_c;
  logic        split_c;
  out_word_t   dec_out;
  entry_t      dec_k;
  entry_t      dec_slot;

  assign rem_c   = pick_e_r.length - {5'd0, req_r.request_size};
  assign split_c = rem_c >= {5'd0, thr_r};

  always_comb begin
    dec_out  = '0;
    dec_k    = pick_e_r;
    dec_slot = '0;
    if (req_r.func == FUNC_ALLOC) begin
      if (req_r.request_size == 16'd0 || !pick_ok_r) begin
        dec_out.status = ST_NOFIT;
      end else if (split_c && !slot_ok_r) begin
        dec_out.status = ST_FULL;
      end else begin
        dec_out.status          = ST_OK;
        dec_out.granted_address = pick_e_r.start[14:0];
        dec_out.granted_id      = last_id_r + 16'd1;
        dec_k.used              = 1'b1;
        dec_k.tag               = last_id_r + 16'd1;
        dec_slot.valid          = 1'b1;
        dec_slot.start          = pick_e_r.start + {5'd0, req_r.request_size};
        dec_slot.length         = rem_c;
        if (split_c) begin
          dec_k.length           = {5'd0, req_r.request_size};
          dec_out.granted_length = req_r.request_size;
        end else begin
          dec_out.granted_length = pick_e_r.length[15:0];
        end
      end
    end else if (!rel_ok_r) begin
      dec_out.status = ST_UNKNOWN;
    end else begin
      dec_out.status          = ST_OK;
      dec_out.granted_address = k_e_r.start[14:0];
      dec_out.granted_length  = k_e_r.length[15:0];
      dec_out.granted_id      = req_r.block_id;
      dec_k                   = k_e_r;
      dec_k.used              = 1'b0;
      dec_k.tag               = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (last_step) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (req_r.func == FUNC_RELEASE && rel_ok_r) begin
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_MERGE:  if (last_step) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != S_IDLE);
    cfg_ready = 1'b1;
    ctl.shift = (state_r == S_SCAN) || (state_r == S_MERGE);
  end

  // Write-back happens in S_WRITE with the ring back in its home position.
  logic [20:0] k_end;
  assign k_end = k_e_r.start + k_e_r.length;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      load[i]   = 1'b0;
      load_e[i] = cells[i];
    end
    if (state_r == S_WRITE && out_r.status == ST_OK) begin
      if (req_r.func == FUNC_ALLOC) begin
        load[pick_pos_r]   = 1'b1;
        load_e[pick_pos_r] = new_k_r;
        if (do_split_r) begin
          load[slot_pos_r]   = 1'b1;
          load_e[slot_pos_r] = new_slot_r;
        end
      end else begin
        if (below_ok_r) begin
          load[below_pos_r]         = 1'b1;
          load_e[below_pos_r]       = below_e_r;
          load_e[below_pos_r].length = below_e_r.length + new_k_r.length;
          load[k_pos_r]             = 1'b1;
          load_e[k_pos_r]           = '0;
        end else begin
          load[k_pos_r]   = 1'b1;
          load_e[k_pos_r] = new_k_r;
        end
        if (above_ok_r) begin
          load[above_pos_r]   = 1'b1;
          load_e[above_pos_r] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fit_r     <= FIT_FIRST;
      thr_r     <= 16'd16;
      last_id_r <= '0;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_POLICY) fit_r <= cfg_data[1:0];
        else                             thr_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (start) begin
            req_r      <= in_word;
            pick_ok_r  <= 1'b0;
            slot_ok_r  <= 1'b0;
            rel_ok_r   <= 1'b0;
            above_ok_r <= 1'b0;
            below_ok_r <= 1'b0;
          end
        end
        S_SCAN: begin
          cnt_r <= last_step ? '0 : cnt_r + 1'b1;
          if (!head.valid && !slot_ok_r) begin
            slot_ok_r  <= 1'b1;
            slot_pos_r <= pos;
          end
          if (fits && (!pick_ok_r || better)) begin
            pick_ok_r  <= 1'b1;
            pick_pos_r <= pos;
            pick_e_r   <= head;
          end
          if (head.valid && head.used && head.tag == req_r.block_id && !rel_ok_r) begin
            rel_ok_r <= 1'b1;
            k_pos_r  <= pos;
            k_e_r    <= head;
          end
        end
        S_DECIDE: begin
          out_r      <= dec_out;
          new_k_r    <= dec_k;
          new_slot_r <= dec_slot;
          do_split_r <= split_c;
          if (req_r.func == FUNC_ALLOC && dec_out.status == ST_OK) begin
            last_id_r <= last_id_r + 16'd1;
          end
        end
        S_MERGE: begin
          // Free neighbours; the lowest index wins, as in the first match.
          cnt_r <= last_step ? '0 : cnt_r + 1'b1;
          if (pos != k_pos_r && head.valid && !head.used && head.start == k_end
              && !above_ok_r) begin
            above_ok_r  <= 1'b1;
            above_pos_r <= pos;
            new_k_r.length <= new_k_r.length + head.length;
          end
          if (pos != k_pos_r && head.valid && !head.used
              && head.start + head.length == k_e_r.start && !below_ok_r) begin
            below_ok_r  <= 1'b1;
            below_pos_r <= pos;
            below_e_r   <= head;
          end
        end
        S_WRITE: begin
          out_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

[rtl/core/vpa_checker.sv]
`default_nettype none
module vpa_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input vpa_pkg::out_word_t     out_word
);
  import vpa_pkg::*;

  // A request always makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

  // A result word is never shown while idle before it.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");

  // Results last one cycle.
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");

  // An error word carries zero fields; granted_id is the field checked here.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.granted_id == 16'd0)
    else $error("error word not cleared");

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_word (out_word)
);
`default_nettype wire

[tb/variable_partition_allocator_tb.sv]
`default_nettype none
module variable_partition_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vpa_pkg::*;

  localparam int SLOTS = 16;
  localparam int MEM_BYTES = 32768;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  variable_partition_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the partition table.
  logic [31:0] part_start [SLOTS];
  logic [31:0] part_len [SLOTS];
  logic part_used [SLOTS];
  logic part_valid [SLOTS];
  logic [15:0] part_tag [SLOTS];
  logic [15:0] last_id;
  fit_t policy;
  logic [15:0] threshold;

  out_word_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int idle_pct = 0;
  int idle_cycles = 0;
  bit done = 1'b0;

  function automatic bit beats(int cand, int best);
    logic lower;
    lower = part_start[cand] < part_start[best];
    if (policy == FIT_WORST) begin
      return part_len[cand] > part_len[best] ||
             (part_len[cand] == part_len[best] && lower);
    end
    if (policy == FIT_BEST) begin
      return part_len[cand] < part_len[best] ||
             (part_len[cand] == part_len[best] && lower);
    end
    return lower;
  endfunction

  function automatic out_word_t allocate(logic [15:0] req);
    out_word_t r;
    int pick;
    int slot;
    logic [31:0] rem;
    r = '0;
    pick = -1;
    slot = -1;
    if (req == 0) begin
      r.status = ST_NOFIT;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (part_valid[i] && !part_used[i] && part_len[i] > req &&
          (pick < 0 || beats(i, pick))) pick = i;
    end
    if (pick < 0) begin
      r.status = ST_NOFIT;
      return r;
    end
    rem = part_len[pick] - req;
    if (rem >= threshold) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!part_valid[i]) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      part_valid[slot] = 1'b1;
      part_used[slot] = 1'b0;
      part_start[slot] = part_start[pick] + req;
      part_len[slot] = rem;
      part_tag[slot] = '0;
      part_len[pick] = req;
    end
    last_id = last_id + 16'd1;
    part_used[pick] = 1'b1;
    part_tag[pick] = last_id;
    r.status = ST_OK;
    r.granted_address = part_start[pick][14:0];
    r.granted_length = part_len[pick][15:0];
    r.granted_id = last_id;
    return r;
  endfunction

  function automatic out_word_t release_id(logic [15:0] id);
    out_word_t r;
    int k;
    r = '0;
    k = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (part_valid[i] && part_used[i] && part_tag[i] == id) k = i;
    end
    if (k < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    r.status = ST_OK;
    r.granted_address = part_start[k][14:0];
    r.granted_length = part_len[k][15:0];
    r.granted_id = id;
    part_used[k] = 1'b0;
    part_tag[k] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != k && part_valid[i] && !part_used[i] &&
          part_start[i] == part_start[k] + part_len[k]) begin
        part_len[k] += part_len[i];
        part_valid[i] = 1'b0;
        part_start[i] = '0;
        part_len[i] = '0;
        break;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (i != k && part_valid[i] && !part_used[i] &&
          part_start[i] + part_len[i] == part_start[k]) begin
        part_len[i] += part_len[k];
        part_valid[k] = 1'b0;
        part_start[k] = '0;
        part_len[k] = '0;
        break;
      end
    end
    return r;
  endfunction

  task automatic send_word(logic func, logic [15:0] size, logic [15:0] id);
    in_word_t w;
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    w.func = func;
    w.request_size = size;
    w.block_id = id;
    start <= 1'b1;
    in_word <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(func == FUNC_ALLOC ? allocate(size) : release_id(id));
    words_sent++;
    start <= 1'b0;
    in_word <= '0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == CFG_FIT_POLICY) policy = fit_t'(value[1:0]);
    else threshold = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] live_id();
    int n;
    int pick;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (part_valid[i] && part_used[i]) n++;
    if (n == 0) return last_id;
    pick = $urandom_range(n - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (part_valid[i] && part_used[i]) begin
        if (pick == 0) return part_tag[i];
        pick--;
      end
    end
    return last_id;
  endfunction

  function automatic logic [15:0] random_size();
    case ($urandom_range(9))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(32768, 16384));
      2, 3: return 16'($urandom_range(4096, 1));
      default: return 16'($urandom_range(512, 1));
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 50) send_word(FUNC_ALLOC, random_size(), 16'($urandom));
      else if ($urandom_range(9) == 0) send_word(FUNC_RELEASE, 16'($urandom), 16'($urandom));
      else send_word(FUNC_RELEASE, 16'($urandom), live_id());
    end
  endtask

  task automatic test_directed();
    send_word(FUNC_ALLOC, 16'd0, 16'hffff);
    send_word(FUNC_ALLOC, 16'd32768, 16'd0);
    send_word(FUNC_ALLOC, 16'hffff, 16'd0);
    send_word(FUNC_ALLOC, 16'd1, 16'd0);
    send_word(FUNC_ALLOC, 16'd32766, 16'd0);
    send_word(FUNC_RELEASE, 16'hffff, 16'd1);
    send_word(FUNC_RELEASE, 16'd0, 16'd1);
    send_word(FUNC_RELEASE, 16'd0, 16'hffff);
    send_word(FUNC_RELEASE, 16'd0, 16'd0);
    send_word(FUNC_RELEASE, 16'd0, 16'd2);
    for (int i = 0; i < 17; i++) send_word(FUNC_ALLOC, 16'd100, 16'd0);
    send_word(FUNC_RELEASE, 16'd0, 16'd5);
    send_word(FUNC_RELEASE, 16'd0, 16'd7);
    send_word(FUNC_RELEASE, 16'd0, 16'd6);
    drain();
  endtask

  task automatic test_policies();
    fit_t modes[4] = '{FIT_WORST, FIT_BEST, FIT_FIRST, FIT_SPARE};
    logic [15:0] limits[4] = '{16'd0, 16'd32768, 16'd1, 16'd16};
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_FIT_POLICY, 16'(modes[m]));
      write_reg(CFG_SPLIT, limits[m]);
      random_phase(120);
      drain();
    end
  endtask

  task automatic test_id_wrap();
    write_reg(CFG_FIT_POLICY, 16'(FIT_FIRST));
    write_reg(CFG_SPLIT, 16'd32768);
    for (int i = 0; i < 200; i++) begin
      send_word(FUNC_ALLOC, 16'd1, 16'd0);
      send_word(FUNC_RELEASE, 16'd0, last_id);
    end
    drain();
  endtask

  task automatic test_random_mix();
    int pace[3] = '{26, 52, 0};
    for (int p = 0; p < 3; p++) begin
      idle_pct = pace[p];
      for (int j = 0; j < 4; j++) begin
        write_reg(CFG_FIT_POLICY, 16'($urandom_range(3)));
        write_reg(CFG_SPLIT, $urandom_range(3) == 0 ? 16'($urandom_range(32768))
                                                   : 16'($urandom_range(64)));
        random_phase(40);
        drain();
      end
    end
  endtask

  always @(negedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_word);
        errors++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_word.status !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, out_word.status);
          errors++;
        end
        if (out_word.granted_address !== exp_word.granted_address) begin
          $error("granted_address: expected %0d, got %0d",
                 exp_word.granted_address, out_word.granted_address);
          errors++;
        end
        if (out_word.granted_length !== exp_word.granted_length) begin
          $error("granted_length: expected %0d, got %0d",
                 exp_word.granted_length, out_word.granted_length);
          errors++;
        end
        if (out_word.granted_id !== exp_word.granted_id) begin
          $error("granted_id: expected %0d, got %0d",
                 exp_word.granted_id, out_word.granted_id);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= WATCH_LIMIT) begin
      $display("variable_partition_allocator_tb failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      part_start[i] = '0;
      part_len[i] = '0;
      part_used[i] = 1'b0;
      part_valid[i] = 1'b0;
      part_tag[i] = '0;
    end
    part_len[0] = MEM_BYTES;
    part_valid[0] = 1'b1;
    part_tag[0] = 16'd1;
    last_id = '0;
    policy = FIT_FIRST;
    threshold = 16'd16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 26;
    test_directed();
    test_policies();
    test_id_wrap();
    test_random_mix();
    drain();
    done = 1'b1;
    $display("Sent %0d words and checked %0d results across all fit policies,",
             words_sent, results_seen);
    $display("split thresholds from 0 to 32768, id reuse and idle gaps.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("variable_partition_allocator_tb passed");
    end else begin
      $display("variable_partition_allocator_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/core/vpa_pkg.sv
rtl/core/vpa_cell.sv
rtl/core/variable_partition_allocator.sv
rtl/core/vpa_checker.sv
tb/variable_partition_allocator_tb.sv
